@@ rtl/rcc_pkg.sv @@
// Shared types and constants for the resource container checker.
package rcc_pkg;

   // Walk phase, one-hot
   typedef enum logic [4:0] {
      PH_FILE = 5'b00001,
      PH_PAD  = 5'b00010,
      PH_HDR  = 5'b00100,
      PH_BODY = 5'b01000,
      PH_DEAD = 5'b10000
   } phase_type;

   // Final status codes
   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_SECTERR = 3'd1;
   localparam logic [2:0] ST_BADSIG  = 3'd2;
   localparam logic [2:0] ST_BADHDR  = 3'd3;
   localparam logic [2:0] ST_PASTEND = 3'd4;

   // Result kinds
   localparam logic KIND_SECTION = 1'b0;
   localparam logic KIND_FINAL   = 1'b1;

   // Fixed words
   localparam logic [31:0] SIG_WORD   = 32'h2053_4552;  // "RES "
   localparam logic [31:0] CNST_WORD  = 32'h5453_4E43;  // "CNST"
   localparam logic [31:0] MAGIC_WORD = 32'h8000_0000;

   // Byte indexes within the file header
   localparam logic [4:0] FH_SIG_IDX  = 5'd3;
   localparam logic [4:0] FH_SIZE_IDX = 5'd7;
   localparam logic [4:0] FH_LAST_IDX = 5'd11;

   // Byte indexes within a section header
   localparam logic [4:0] SH_START_IDX = 5'd0;
   localparam logic [4:0] SH_TAG_IDX   = 5'd3;
   localparam logic [4:0] SH_SIZE_IDX  = 5'd7;
   localparam logic [4:0] SH_MAGIC_IDX = 5'd11;
   localparam logic [4:0] SH_ZERO_IDX  = 5'd15;
   localparam logic [4:0] SH_LAST_IDX  = 5'd19;

   // Section end sits this far past the first header byte, plus data size
   localparam int unsigned SEC_BASE_BYTES = 8;

   // Output queue
   localparam int unsigned QDEPTH = 4;
   localparam int unsigned QPTR_W = 2;
   localparam int unsigned QCNT_W = 3;

   // Per-section error flags
   typedef struct packed {
      logic cnst;
      logic trunc;
   } sflags_type;

   // One result word
   typedef struct packed {
      logic        last;
      logic        kind;
      logic [2:0]  status;
      logic        cnst;
      logic        recon;
      logic        trunc;
      logic [31:0] first;
      logic [31:0] count;
      logic [31:0] tag;
   } result_type;

endpackage

@@ rtl/resource_container_checker.sv @@
// A result is written into the result queue when the byte that causes it is taken, and is offered on rsp from there.
// Throughput: one byte per cycle; the byte-level update is a single combinational pass
// from the state registers into a four-word result queue, which holds req_tready low
// only while fewer than two queue slots are free.
// Reset: synchronous, active high; clears the walk state and empties the queue.
// After the final status word the walk state returns to its reset values for a new file.
module resource_container_checker #(
   parameter int POSITION_BITS = 32,
   parameter int MAX_PAD_BYTES = 4
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // [7:0] data_byte
   input  logic         req_tlast,   // last_byte
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [31:0] tag_word, [63:32] record_count, [95:64] first_length, [96] err_truncated,
   // [97] err_reconcile, [98] err_cnst_count, [101:99] file_status, [103:102] zero
   output logic [103:0] rsp_tdata,
   output logic         rsp_tuser,   // item_kind
   output logic         rsp_tlast    // last_result
);
   import rcc_pkg::*;

   localparam int PW = POSITION_BITS;
   localparam int EW = POSITION_BITS + 2;
   localparam int CW = ((EW > 32) ? EW : 32) + 2;
   localparam logic [PW-1:0] POS_MAX = {PW{1'b1}};
   localparam logic [EW-1:0] END_MAX = {EW{1'b1}};

   // Walk state
   phase_type     phase_ff, phase_in;
   logic [PW-1:0] pos_ff, pos_in;
   logic [4:0]    idx_ff, idx_in;
   logic [31:0]   asm_ff, asm_in;
   logic [31:0]   ctag_ff, ctag_in;
   logic [31:0]   tsize_ff, tsize_in;
   logic [31:0]   stag_ff, stag_in;
   logic [EW-1:0] send_ff, send_in;
   logic [31:0]   scount_ff, scount_in;
   logic [31:0]   first_ff, first_in;
   logic [31:0]   ridx_ff, ridx_in;
   logic [EW-1:0] cursor_ff, cursor_in;
   logic [2:0]    pad_ff, pad_in;
   sflags_type    flags_ff, flags_in;
   logic          anyerr_ff, anyerr_in;
   logic          isconst_ff, isconst_in;
   logic [2:0]    fatal_ff, fatal_in;

   // Result queue
   result_type        q_mem [QDEPTH];
   logic [QPTR_W-1:0] wptr_ff, wptr_in;
   logic [QPTR_W-1:0] rptr_ff, rptr_in;
   logic [QCNT_W-1:0] qcnt_ff, qcnt_in;

   logic          acc;
   logic          pop;
   logic [7:0]    b;
   logic [31:0]   asm_new;
   logic [EW-1:0] pos_e;
   logic [EW-1:0] pos1_e;
   logic [EW-1:0] pos5_e;
   logic [EW-1:0] pos8_e;
   logic          sec_valid;
   logic          fin_valid;
   result_type    sec_res;
   result_type    fin_res;
   result_type    head;

   assign acc     = req_tvalid & req_tready;
   assign pop     = rsp_tvalid & rsp_tready;
   assign b       = req_tdata;
   assign asm_new = {b, asm_ff[31:8]};
   assign pos_e   = EW'(pos_ff);
   assign pos1_e  = pos_e + EW'(1);
   assign pos5_e  = pos_e + EW'(5);
   assign pos8_e  = pos_e + EW'(SEC_BASE_BYTES);

   // Byte update: file header, padding, section header, body walk, reports
   always_comb begin
      logic          hdr_go;
      logic          end_chk;
      logic [4:0]    idx_cur;
      logic [2:0]    fcode;
      logic [31:0]   limit;
      logic [CW-1:0] csum;
      logic          recon;
      logic [2:0]    st;

      phase_in   = phase_ff;
      pos_in     = pos_ff;
      idx_in     = idx_ff;
      asm_in     = asm_ff;
      ctag_in    = ctag_ff;
      tsize_in   = tsize_ff;
      stag_in    = stag_ff;
      send_in    = send_ff;
      scount_in  = scount_ff;
      first_in   = first_ff;
      ridx_in    = ridx_ff;
      cursor_in  = cursor_ff;
      pad_in     = pad_ff;
      flags_in   = flags_ff;
      anyerr_in  = anyerr_ff;
      isconst_in = isconst_ff;
      fatal_in   = fatal_ff;
      hdr_go     = 1'b0;
      end_chk    = 1'b0;
      idx_cur    = idx_ff;
      fcode      = fatal_ff;
      limit      = 32'd0;
      csum       = '0;
      recon      = 1'b0;
      st         = ST_OK;
      sec_valid  = 1'b0;
      fin_valid  = 1'b0;
      sec_res    = '0;
      fin_res    = '0;

      if (acc) begin
         asm_in = asm_new;
         case (phase_ff)
            PH_FILE: begin
               if (idx_ff == FH_SIG_IDX && asm_new != SIG_WORD) begin
                  phase_in = PH_DEAD;
                  fatal_in = ST_BADSIG;
               end else if (idx_ff >= FH_LAST_IDX) begin
                  ctag_in  = asm_new;
                  phase_in = PH_PAD;
                  pad_in   = 3'd0;
               end else begin
                  if (idx_ff == FH_SIZE_IDX) begin
                     tsize_in = asm_new;
                  end
                  idx_in = idx_ff + 5'd1;
               end
            end
            PH_PAD: begin
               if (b == 8'd0 && pad_ff < 3'(MAX_PAD_BYTES)) begin
                  pad_in = pad_ff + 3'd1;
               end else begin
                  phase_in = PH_HDR;
                  hdr_go   = 1'b1;
                  idx_cur  = SH_START_IDX;
               end
            end
            PH_HDR: begin
               hdr_go = 1'b1;
            end
            PH_BODY: begin
               limit = isconst_ff ? 32'd1 : scount_ff;
               // a length prefix completes on its fourth byte
               if (!flags_ff.trunc && ridx_ff < limit &&
                   ({1'b0, cursor_ff} + (EW+1)'(3)) == {1'b0, pos_e}) begin
                  csum = CW'(cursor_ff) + CW'(4) + CW'(asm_new);
                  if (ridx_ff == 32'd0) begin
                     first_in = asm_new;
                  end
                  cursor_in = (csum > CW'(END_MAX)) ? END_MAX : EW'(csum);
                  ridx_in   = ridx_ff + 32'd1;
                  if (ridx_in < limit &&
                      ({1'b0, cursor_in} + (EW+1)'(4)) > {1'b0, send_ff}) begin
                     flags_in.trunc = 1'b1;
                  end
               end
               end_chk = 1'b1;
            end
            default: begin
            end
         endcase

         // Section header bytes
         if (hdr_go) begin
            idx_in = idx_cur + 5'd1;
            if (idx_cur == SH_START_IDX) begin
               send_in  = pos8_e;
               fatal_in = ST_OK;
            end else if (idx_cur == SH_TAG_IDX) begin
               stag_in    = asm_new;
               isconst_in = (asm_new == CNST_WORD);
            end else if (idx_cur == SH_SIZE_IDX) begin
               send_in = send_ff + EW'(asm_new);
            end else if (idx_cur == SH_MAGIC_IDX) begin
               if (asm_new != MAGIC_WORD) begin
                  fatal_in = ST_BADHDR;
               end
            end else if (idx_cur == SH_ZERO_IDX) begin
               if (asm_new != 32'd0) begin
                  fatal_in = ST_BADHDR;
               end
            end else if (idx_cur >= SH_LAST_IDX) begin
               idx_in    = idx_cur;
               scount_in = asm_new;
               fcode     = fatal_ff;
               if (send_ff < pos1_e) begin
                  fcode = ST_BADHDR;
               end
               if (isconst_ff && send_ff < pos5_e) begin
                  fcode = ST_BADHDR;
               end
               fatal_in = fcode;
               if (fcode != ST_OK) begin
                  phase_in = PH_DEAD;
               end else begin
                  limit          = isconst_ff ? 32'd1 : asm_new;
                  cursor_in      = pos1_e;
                  ridx_in        = 32'd0;
                  first_in       = 32'd0;
                  flags_in.cnst  = isconst_ff && (asm_new != 32'd1);
                  flags_in.trunc = (limit != 32'd0) && (pos5_e > send_ff);
                  phase_in       = PH_BODY;
                  end_chk        = 1'b1;
               end
            end
         end

         // Section report on the last byte of the section
         if (end_chk && pos1_e == send_in) begin
            recon = (cursor_in != send_in);
            if (flags_in.trunc || flags_in.cnst || recon) begin
               anyerr_in = 1'b1;
            end
            sec_valid     = 1'b1;
            sec_res.kind  = KIND_SECTION;
            sec_res.tag   = stag_in;
            sec_res.count = scount_in;
            sec_res.first = first_in;
            sec_res.trunc = flags_in.trunc;
            sec_res.recon = recon;
            sec_res.cnst  = flags_in.cnst;
            phase_in      = PH_PAD;
            pad_in        = 3'd0;
         end

         if (pos_ff < POS_MAX) begin
            pos_in = pos_ff + PW'(1);
         end

         // Final status word, then back to the reset state
         if (req_tlast) begin
            case (phase_in)
               PH_DEAD: st = fatal_in;
               PH_FILE: st = ST_BADSIG;
               PH_BODY: st = ST_PASTEND;
               default: st = anyerr_in ? ST_SECTERR : ST_OK;
            endcase
            fin_valid      = 1'b1;
            fin_res.kind   = KIND_FINAL;
            fin_res.last   = 1'b1;
            fin_res.status = st;
            if (st != ST_BADSIG) begin
               fin_res.tag   = ctag_in;
               fin_res.count = tsize_in;
            end
            phase_in   = PH_FILE;
            pos_in     = '0;
            idx_in     = '0;
            asm_in     = '0;
            ctag_in    = '0;
            tsize_in   = '0;
            stag_in    = '0;
            send_in    = '0;
            scount_in  = '0;
            first_in   = '0;
            ridx_in    = '0;
            cursor_in  = '0;
            pad_in     = '0;
            flags_in   = '0;
            anyerr_in  = 1'b0;
            isconst_in = 1'b0;
            fatal_in   = ST_OK;
         end
      end
   end

   // Walk state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_FILE;
         pos_ff     <= '0;
         idx_ff     <= '0;
         asm_ff     <= '0;
         ctag_ff    <= '0;
         tsize_ff   <= '0;
         stag_ff    <= '0;
         send_ff    <= '0;
         scount_ff  <= '0;
         first_ff   <= '0;
         ridx_ff    <= '0;
         cursor_ff  <= '0;
         pad_ff     <= '0;
         flags_ff   <= '0;
         anyerr_ff  <= 1'b0;
         isconst_ff <= 1'b0;
         fatal_ff   <= ST_OK;
      end else begin
         phase_ff   <= phase_in;
         pos_ff     <= pos_in;
         idx_ff     <= idx_in;
         asm_ff     <= asm_in;
         ctag_ff    <= ctag_in;
         tsize_ff   <= tsize_in;
         stag_ff    <= stag_in;
         send_ff    <= send_in;
         scount_ff  <= scount_in;
         first_ff   <= first_in;
         ridx_ff    <= ridx_in;
         cursor_ff  <= cursor_in;
         pad_ff     <= pad_in;
         flags_ff   <= flags_in;
         anyerr_ff  <= anyerr_in;
         isconst_ff <= isconst_in;
         fatal_ff   <= fatal_in;
      end
   end

   // Queue pointers and fill count
   always_comb begin
      wptr_in = wptr_ff + QPTR_W'(sec_valid) + QPTR_W'(fin_valid);
      rptr_in = rptr_ff + QPTR_W'(pop);
      qcnt_in = qcnt_ff + QCNT_W'(sec_valid) + QCNT_W'(fin_valid) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         qcnt_ff <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         qcnt_ff <= qcnt_in;
      end
   end

   // Queue storage: a section report goes first, the final status right behind it
   always_ff @(posedge clock) begin
      if (sec_valid) begin
         q_mem[wptr_ff] <= sec_res;
      end
      if (fin_valid) begin
         q_mem[wptr_ff + QPTR_W'(sec_valid)] <= fin_res;
      end
   end

   // Ports
   assign head       = q_mem[rptr_ff];
   assign req_tready = (qcnt_ff <= QCNT_W'(QDEPTH - 2));
   assign rsp_tvalid = (qcnt_ff != '0);
   assign rsp_tdata  = {2'b00, head.status, head.cnst, head.recon, head.trunc,
                        head.first, head.count, head.tag};
   assign rsp_tuser  = head.kind;
   assign rsp_tlast  = head.last;

endmodule
